// ===== rtl/mms_pkg.sv =====
`timescale 1ns / 1ps
package mms_pkg;

  // default sizes, overridable on the top level
  localparam int SLOT_COUNT_DEF   = 8;
  localparam int SOURCE_COUNT_DEF = 16;

  // fixed field widths
  localparam int SRC_W      = 4;
  localparam int DST_W      = 5;
  localparam int VAL_W      = 16;
  localparam int MASK_W     = 8;
  localparam int CFG_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // slot register packing
  localparam int CFG_EN_BIT  = 25;
  localparam int CFG_SRC_LSB = 21;
  localparam int CFG_DST_LSB = 16;

  // q2.14 constants
  localparam int ONE_Q14  = 16384;
  localparam int ONE_Q28  = 268435456;
  localparam int HALF_LSB = 8192;
  localparam int FRAC_W   = 14;

  typedef enum logic {
    ACT_SET   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // one routing slot plus a shadow copy of its source value
  typedef struct packed {
    logic                    on;
    logic [SRC_W-1:0]        src;
    logic [DST_W-1:0]        dst;
    logic signed [VAL_W-1:0] amt;
    logic signed [VAL_W-1:0] val;
  } slot_t;

endpackage

// ===== rtl/mms_slot_bank.sv =====
`timescale 1ns / 1ps
module mms_slot_bank #(
  parameter int SLOT_COUNT   = mms_pkg::SLOT_COUNT_DEF,
  parameter int SOURCE_COUNT = mms_pkg::SOURCE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mms_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              set_we,
  input  logic [mms_pkg::SRC_W-1:0]         set_index,
  input  logic signed [mms_pkg::VAL_W-1:0]  set_value,
  output mms_pkg::slot_t [SLOT_COUNT-1:0]   slots
);
  import mms_pkg::*;

  logic signed [VAL_W-1:0] source_values [SOURCE_COUNT];
  logic signed [VAL_W-1:0] cfg_amt_raw;
  logic signed [VAL_W-1:0] cfg_amt;
  logic [SRC_W-1:0]        cfg_src;
  logic signed [VAL_W-1:0] cfg_val;
  logic                    set_in_range;

  assign cfg_src      = cfg_data[CFG_SRC_LSB +: SRC_W];
  assign cfg_amt_raw  = $signed(cfg_data[VAL_W-1:0]);
  assign set_in_range = (int'(set_index) < SOURCE_COUNT);

  // amount clamp to +/-1.0 at write time
  always_comb begin
    if (cfg_amt_raw > $signed(VAL_W'(ONE_Q14))) begin
      cfg_amt = $signed(VAL_W'(ONE_Q14));
    end else if (cfg_amt_raw < -$signed(VAL_W'(ONE_Q14))) begin
      cfg_amt = -$signed(VAL_W'(ONE_Q14));
    end else begin
      cfg_amt = cfg_amt_raw;
    end
  end

  // current value of the source a slot is being pointed at; out of range reads zero
  always_comb begin
    cfg_val = '0;
    for (int j = 0; j < SOURCE_COUNT; j++) begin
      if (cfg_src == SRC_W'(j)) begin
        cfg_val = source_values[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SOURCE_COUNT; j++) begin
        source_values[j] <= '0;
      end
    end else if (set_we) begin
      for (int j = 0; j < SOURCE_COUNT; j++) begin
        if (set_index == SRC_W'(j)) begin
          source_values[j] <= set_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (rst) begin
        slots[i].on <= 1'b0;
      end else if (cfg_we && cfg_index == CFG_IDX_W'(i)) begin
        slots[i].on  <= cfg_data[CFG_EN_BIT];
        slots[i].src <= cfg_src;
        slots[i].dst <= cfg_data[CFG_DST_LSB +: DST_W];
        slots[i].amt <= cfg_amt;
        slots[i].val <= cfg_val;
      end else if (set_we && set_in_range && slots[i].src == set_index) begin
        // keep the shadow copy in step with the source store
        slots[i].val <= set_value;
      end
    end
  end

endmodule

// ===== rtl/mms_accum.sv =====
`timescale 1ns / 1ps
module mms_accum #(
  parameter int SLOT_COUNT = mms_pkg::SLOT_COUNT_DEF
) (
  input  mms_pkg::slot_t [SLOT_COUNT-1:0]   slots,
  input  logic [mms_pkg::DST_W-1:0]         destination,
  output logic signed [mms_pkg::VAL_W-1:0]  modulation,
  output logic [mms_pkg::MASK_W-1:0]        active_mask
);
  import mms_pkg::*;

  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = PROD_W + $clog2(SLOT_COUNT + 1);
  localparam int CLAMP_W = 30;

  logic signed [PROD_W-1:0]  prod [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]     hit;
  logic signed [SUM_W-1:0]   sum;
  logic signed [CLAMP_W-1:0] clamped;
  logic signed [CLAMP_W-1:0] rounded;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]  = slots[i].on && (slots[i].dst == destination);
      prod[i] = slots[i].val * slots[i].amt;
    end
  end

  always_comb begin
    active_mask = '0;
    active_mask[SLOT_COUNT-1:0] = hit;
  end

  // source none matches but adds nothing
  always_comb begin
    sum = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit[i] && slots[i].src != '0) begin
        sum = sum + SUM_W'(prod[i]);
      end
    end
  end

  // clamp to +/-1.0 in q4.28, then round half up to q2.14
  always_comb begin
    if (sum > $signed(SUM_W'(ONE_Q28))) begin
      clamped = $signed(CLAMP_W'(ONE_Q28));
    end else if (sum < -$signed(SUM_W'(ONE_Q28))) begin
      clamped = -$signed(CLAMP_W'(ONE_Q28));
    end else begin
      clamped = sum[CLAMP_W-1:0];
    end
    rounded    = (clamped + $signed(CLAMP_W'(HALF_LSB))) >>> FRAC_W;
    modulation = rounded[VAL_W-1:0];
  end

endmodule

// ===== rtl/modulation_matrix_sum_core.sv =====
`timescale 1ns / 1ps
// Modulation matrix: one stored q2.14 value per source and SLOT_COUNT routing slots
// written through the cfg port. A transfer with tuser = set stores a source value and
// gives no result; the store takes effect at the accepting edge, so any later query
// sees it. A transfer with tuser = query gives one result: the sum of value times
// amount over enabled slots aimed at that destination with a source other than none,
// clamped to +/-1.0 and rounded half up, plus a mask of enabled slots aimed there.
// A query goes through the query register, then the result register, and waits in the
// query register while the result is stalled; one transfer is taken each cycle unless
// a query waits behind a stalled result. The product and adder path between the two is
// combinational. Slot amounts are clamped to +/-1.0 when written. The user must write
// slots only while no transfer is in flight; the block itself does not enforce this.
module modulation_matrix_sum_core #(
  parameter int SLOT_COUNT   = mms_pkg::SLOT_COUNT_DEF,
  parameter int SOURCE_COUNT = mms_pkg::SOURCE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes, register i = slot i
  input  logic                              cfg_we,
  input  logic [mms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mms_pkg::CFG_W-1:0]         cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] source_index, [19:4] source_value, [24:20] destination, [31:25] zero
  input  logic [mms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] action
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] modulation, [23:16] active_mask
  output logic [mms_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import mms_pkg::*;

  mms_pkg::slot_t [SLOT_COUNT-1:0] slots;

  logic                    in_transfer;
  logic                    set_we;
  logic [SRC_W-1:0]        in_source_index;
  logic signed [VAL_W-1:0] in_source_value;
  logic [DST_W-1:0]        in_destination;

  // query register
  logic             query_valid;
  logic [DST_W-1:0] query_dest;
  logic             out_free;
  logic             query_advance;

  logic signed [VAL_W-1:0] sum_modulation;
  logic [MASK_W-1:0]       sum_mask;

  // unpack the input transfer
  assign in_source_index = s_axis_tdata[SRC_W-1:0];
  assign in_source_value = $signed(s_axis_tdata[SRC_W +: VAL_W]);
  assign in_destination  = s_axis_tdata[SRC_W+VAL_W +: DST_W];

  // result register free when empty or being taken this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign query_advance = query_valid && out_free;
  // a query held behind a stalled result also blocks sets, so it never sees a later store
  assign s_axis_tready = !query_valid || out_free;
  assign in_transfer   = s_axis_tvalid && s_axis_tready;
  assign set_we        = in_transfer && (action_t'(s_axis_tuser) == ACT_SET);

  mms_slot_bank #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .set_we    (set_we),
    .set_index (in_source_index),
    .set_value (in_source_value),
    .slots     (slots)
  );

  mms_accum #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_accum (
    .slots       (slots),
    .destination (query_dest),
    .modulation  (sum_modulation),
    .active_mask (sum_mask)
  );

  // query stage
  always_ff @(posedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
    end else if (in_transfer && action_t'(s_axis_tuser) == ACT_QUERY) begin
      query_valid <= 1'b1;
    end else if (query_advance) begin
      query_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer && action_t'(s_axis_tuser) == ACT_QUERY) begin
      query_dest <= in_destination;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (query_advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (query_advance) begin
      m_axis_tdata <= {sum_mask, sum_modulation};
    end
  end

endmodule

// ===== rtl/mms_checker.sv =====
`timescale 1ns / 1ps
module mms_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mms_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import mms_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // result never leaves +/-1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[VAL_W-1:0]) <= $signed(VAL_W'(ONE_Q14))) &&
                      ($signed(m_axis_tdata[VAL_W-1:0]) >= -$signed(VAL_W'(ONE_Q14))))
    else $error("modulation out of range");

  // input only back-pressured by a stalled result
  a_bp: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // nothing pending straight after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind modulation_matrix_sum_core mms_checker u_mms_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/modulation_matrix_sum_core_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for the modulation matrix core
module modulation_matrix_sum_core_test;
  import mms_pkg::*;

  // receiver behaviour on the result stream
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  // one routing slot as seen by the predictor, amount already clamped
  typedef struct {
    bit                      on;
    logic [SRC_W-1:0]        src;
    logic [DST_W-1:0]        dst;
    logic signed [VAL_W-1:0] amt;
  } route_cfg_t;

  typedef struct {
    logic signed [VAL_W-1:0] modulation;
    logic [MASK_W-1:0]       active_mask;
  } mod_result_t;

  localparam int SLOTS       = 8;
  localparam int SOURCES     = 16;
  localparam int SETTLE_CYC  = 4;   // result path is the query register then the result register, leave margin
  localparam int HOLD_CYC    = 300;
  localparam int PHASE_ITEMS = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // predictor state
  logic signed [VAL_W-1:0] source_level [SOURCES];
  route_cfg_t              route [SLOTS];
  logic [CFG_W-1:0]        routing_plan [SLOTS];
  mod_result_t             pending_results [$];

  int       error_count = 0;
  int       burst_left = 0;
  bit       sender_gaps_on = 1'b1;
  rx_mode_t rx_mode = RX_STEADY;
  int       hold_cycles = 0;
  int       rx_phase = 0;

  modulation_matrix_sum_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // generous limit, far above the slowest legal run
  initial begin
    #3000000;
    $display("[modulation_matrix_sum_core] ERROR");
    $finish;
  end

  // receiver: its own stall pattern plus an optional long hold-off
  always @(posedge clk) begin
    rx_phase = rx_phase + 1;
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      case (rx_mode)
        RX_STEADY:   m_axis_tready <= 1'b1;
        RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 2) != 0);
        RX_PERIODIC: m_axis_tready <= (rx_phase % 5 < 2);
        default:     m_axis_tready <= 1'b1;
      endcase
    end
  end

  // result checker: values sampled mid-cycle hold at the next rising edge
  always @(negedge clk) begin
    mod_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: data %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== want.modulation) begin
          $error("modulation: expected %0d, got %0d", want.modulation,
                 $signed(m_axis_tdata[15:0]));
          error_count++;
        end
        if (m_axis_tdata[23:16] !== want.active_mask) begin
          $error("active_mask: expected %h, got %h", want.active_mask,
                 m_axis_tdata[23:16]);
          error_count++;
        end
      end
    end
  end

  // sum of value times amount over matching slots, clamped and rounded half up
  function automatic mod_result_t predict_modulation(logic [DST_W-1:0] dst);
    mod_result_t r;
    longint      acc;
    acc = 0;
    r.active_mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (route[i].on && route[i].dst == dst) begin
        r.active_mask[i] = 1'b1;
        // source none still shows in the mask but adds nothing
        if (route[i].src != '0)
          acc += longint'(source_level[route[i].src]) * longint'(route[i].amt);
      end
    end
    if (acc > longint'(ONE_Q28)) acc = longint'(ONE_Q28);
    if (acc < -longint'(ONE_Q28)) acc = -longint'(ONE_Q28);
    r.modulation = VAL_W'(((acc + ONE_Q28 + HALF_LSB) >>> FRAC_W) - ONE_Q14);
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] slot_word(bit on, logic [SRC_W-1:0] src,
                                                 logic [DST_W-1:0] dst,
                                                 logic [VAL_W-1:0] amt);
    return {on, src, dst, amt};
  endfunction

  // biased towards the corners of the q2.14 range
  function automatic logic [VAL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'(ONE_Q14);
      3:       return 16'(-ONE_Q14);
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transfer; bursts with random gaps when enabled
  task automatic send_item(action_t act, logic [SRC_W-1:0] sidx,
                           logic [VAL_W-1:0] sval, logic [DST_W-1:0] dst);
    bit taken;
    int gap;
    if (sender_gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, dst, sval, sidx};
    s_axis_tuser  <= act;
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    if (burst_left > 0) burst_left--;
    if (act == ACT_SET) source_level[sidx] = sval;
    else pending_results.insert(pending_results.size(), predict_modulation(dst));
  endtask

  // drop valid, let every result arrive, then let the pipeline settle
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // writes all eight slot registers from routing_plan, only while idle
  task automatic apply_routing();
    logic signed [VAL_W-1:0] amt;
    for (int i = 0; i < SLOTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= routing_plan[i];
      amt = routing_plan[i][15:0];
      if (amt > ONE_Q14) amt = VAL_W'(ONE_Q14);
      if (amt < -ONE_Q14) amt = VAL_W'(-ONE_Q14);
      route[i].on  = routing_plan[i][CFG_EN_BIT];
      route[i].src = routing_plan[i][CFG_SRC_LSB +: SRC_W];
      route[i].dst = routing_plan[i][CFG_DST_LSB +: DST_W];
      route[i].amt = amt;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // everything disabled straight out of reset
  task automatic test_reset_state();
    send_item(ACT_QUERY, 4'hF, 16'hFFFF, 5'd0);
    send_item(ACT_QUERY, 4'h0, 16'h0000, 5'd31);
    wait_for_results();
  endtask

  // hand-built routing around clamps, rounding, source none and disabled slots
  task automatic test_directed_corners();
    routing_plan[0] = slot_word(1'b1, 4'd1, 5'd0, 16'd16384);
    routing_plan[1] = slot_word(1'b1, 4'd2, 5'd0, 16'(-16384));
    routing_plan[2] = slot_word(1'b1, 4'd0, 5'd0, 16'd16384);   // source none
    routing_plan[3] = slot_word(1'b0, 4'd1, 5'd0, 16'd16384);   // disabled
    routing_plan[4] = slot_word(1'b1, 4'd3, 5'd31, 16'h7FFF);   // amount clamps high
    routing_plan[5] = slot_word(1'b1, 4'd3, 5'd31, 16'h8000);   // amount clamps low
    routing_plan[6] = slot_word(1'b1, 4'd15, 5'd31, 16'd1);
    routing_plan[7] = slot_word(1'b1, 4'd4, 5'd5, 16'hFFFF);
    apply_routing();
    // both sources at full scale: sum far above +1.0
    send_item(ACT_SET, 4'd1, 16'h7FFF, 5'd31);
    send_item(ACT_SET, 4'd2, 16'h8000, 5'd0);
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd0);
    // equal and opposite
    send_item(ACT_SET, 4'd2, 16'h7FFF, 5'd17);
    send_item(ACT_QUERY, 4'd7, 16'h1234, 5'd0);
    // far below -1.0
    send_item(ACT_SET, 4'd1, 16'h8000, 5'd0);
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd0);
    // a store to source none is kept but never used
    send_item(ACT_SET, 4'd0, 16'h3039, 5'd0);
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd0);
    // rounding of single lsb products at the half point
    send_item(ACT_SET, 4'd3, 16'h7FFF, 5'd0);
    send_item(ACT_SET, 4'd15, 16'd8192, 5'd0);
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd31);
    send_item(ACT_SET, 4'd15, 16'(-8192), 5'd0);
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd31);
    send_item(ACT_SET, 4'd15, 16'd8191, 5'd0);
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd31);
    send_item(ACT_SET, 4'd4, 16'd16384, 5'd0);
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd5);
    // nothing routed here
    send_item(ACT_QUERY, 4'd0, 16'h0000, 5'd7);
    wait_for_results();
  endtask

  // several routing setups, extremes among them, with random traffic on each
  task automatic test_random_routing();
    int               kind;
    logic [DST_W-1:0] dst;
    logic [DST_W-1:0] shared_dst;
    for (int p = 0; p < 6; p++) begin
      kind = p % 4;
      shared_dst = DST_W'($urandom);
      for (int i = 0; i < SLOTS; i++) begin
        case (kind)
          0: routing_plan[i] = slot_word($urandom_range(0, 3) != 0, SRC_W'($urandom),
                                         DST_W'($urandom_range(0, 2) * 14 + 3),
                                         VAL_W'($urandom));
          1: routing_plan[i] = slot_word(1'b1, SRC_W'(i + 1 + p), shared_dst,
                                         $urandom_range(0, 1) ? 16'd16384 : 16'(-16384));
          2: routing_plan[i] = '0;
          default: routing_plan[i] = '1;
        endcase
      end
      apply_routing();
      rx_mode = rx_mode_t'(p % 3);
      sender_gaps_on = (p % 3 != 0) || (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) < 2) begin
          send_item(ACT_SET, SRC_W'($urandom), pick_level(), DST_W'($urandom));
        end else begin
          if ($urandom_range(0, 4) != 0)
            dst = routing_plan[$urandom_range(0, SLOTS - 1)][CFG_DST_LSB +: DST_W];
          else
            dst = DST_W'($urandom);
          send_item(ACT_QUERY, SRC_W'($urandom), VAL_W'($urandom), dst);
        end
      end
      wait_for_results();
    end
  endtask

  // receiver holds off long enough for the core to fill and stall its input
  task automatic test_back_pressure();
    for (int i = 0; i < SLOTS; i++)
      routing_plan[i] = slot_word(1'b1, SRC_W'(i), DST_W'(i % 2), VAL_W'($urandom));
    apply_routing();
    rx_mode = RX_RANDOM;
    sender_gaps_on = 1'b0;
    @(negedge clk);
    hold_cycles = HOLD_CYC;
    @(posedge clk);
    for (int n = 0; n < 40; n++) begin
      if (n % 4 == 0)
        send_item(ACT_SET, SRC_W'($urandom), pick_level(), DST_W'($urandom));
      else
        send_item(ACT_QUERY, SRC_W'($urandom), VAL_W'($urandom), DST_W'(n % 2));
    end
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < SOURCES; i++) source_level[i] = '0;
    for (int i = 0; i < SLOTS; i++) route[i] = '{1'b0, '0, '0, '0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_corners();
    test_random_routing();
    test_back_pressure();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[modulation_matrix_sum_core] OK");
    end else begin
      $display("[modulation_matrix_sum_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mms_pkg.sv
rtl/mms_slot_bank.sv
rtl/mms_accum.sv
rtl/modulation_matrix_sum_core.sv
rtl/mms_checker.sv
tb/sv/modulation_matrix_sum_core_test.sv
